FILE: hw/rtl/edf_pkg.sv
// edf_pkg: shared types and constants for the EDF task selector.
// Used by edf_front, edf_back and edf_task_selector_unit; no dependencies.
package edf_pkg;

    localparam int SLOTS   = 16;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int CNT_W   = IDX_W + 1;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic REG_TASK_COUNT = 1'b0;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [3:0]  slot;
        logic [7:0]  task_id;
        logic [15:0] exec_time;
    } req_word_t;

    typedef struct packed {
        logic [31:0] time_now;
        logic        busy_res;
        logic [7:0]  run_id;
        logic        finished;
    } rsp_word_t;

    typedef struct packed {
        logic      valid;
        req_word_t word;
    } q_head_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_EMIT
    } bk_state_t;

endpackage

FILE: hw/rtl/edf_task_selector_unit.sv
// edf_task_selector_unit: top level of the EDF task selector, APB register.
// Depends on edf_pkg, edf_front and edf_back.
// A load is queued, then written to the slot table when the idle back end
// pops it. A tick scans task_count slots (capped at 16), one slot per cycle,
// and its result is registered; loads are popped one per cycle while idle,
// but none during a tick. A 4-word queue decouples request acceptance.
// Reset clears the slot table, the tick counter and task_count.
module edf_task_selector_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  edf_pkg::req_word_t           req_word,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output edf_pkg::rsp_word_t           rsp_word,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [edf_pkg::APB_AW-1:0]   paddr,
    input  logic [edf_pkg::APB_DW-1:0]   pwdata,
    output logic [edf_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    logic [4:0]         task_count_reg, task_count_next;
    logic               reg_sel;
    edf_pkg::q_head_t   head;
    logic               pop;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == edf_pkg::REG_TASK_COUNT);
    assign prdata  = reg_sel ? {27'd0, task_count_reg} : '0;

    always_comb
    begin
        task_count_next = task_count_reg;
        if (psel && penable && pwrite && pready && reg_sel)
        begin
            task_count_next = pwdata[4:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg <= '0;
        end
        else
        begin
            task_count_reg <= task_count_next;
        end
    end

    edf_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .head      (head),
        .pop       (pop)
    );

    edf_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .task_count (task_count_reg),
        .head       (head),
        .pop        (pop),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_word   (rsp_word)
    );

endmodule

FILE: hw/rtl/edf_front.sv
// edf_front: accepts request words and queues them for the back end.
// Depends on edf_pkg.
module edf_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  edf_pkg::req_word_t req_word,
    output edf_pkg::q_head_t   head,
    input  logic               pop
);

    edf_pkg::req_word_t               q_mem [edf_pkg::Q_DEPTH];
    logic [edf_pkg::Q_PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [edf_pkg::Q_PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [edf_pkg::Q_CNT_W-1:0]      cnt_reg, cnt_next;
    logic                             push;
    logic                             do_pop;

    assign req_stall = (cnt_reg == edf_pkg::Q_CNT_W'(edf_pkg::Q_DEPTH));
    assign push      = req_valid && !req_stall;
    assign do_pop    = pop && (cnt_reg != '0);

    assign head.valid = (cnt_reg != '0);
    assign head.word  = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= req_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

FILE: hw/rtl/edf_back.sv
// edf_back: slot table, serial minimum-deadline scan and result register.
// Depends on edf_pkg.
module edf_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [4:0]         task_count,
    input  edf_pkg::q_head_t   head,
    output logic               pop,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output edf_pkg::rsp_word_t rsp_word
);

    logic [7:0]                  ident_reg  [edf_pkg::SLOTS];
    logic [15:0]                 remain_reg [edf_pkg::SLOTS];
    logic [15:0]                 dline_reg  [edf_pkg::SLOTS];

    edf_pkg::bk_state_t          state_reg, state_next;
    logic [edf_pkg::CNT_W-1:0]   idx_reg, idx_next;
    logic [edf_pkg::CNT_W-1:0]   limit;
    logic                        found_reg, found_next;
    logic [edf_pkg::IDX_W-1:0]   best_reg, best_next;
    logic [15:0]                 best_dl_reg, best_dl_next;
    logic [7:0]                  best_id_reg, best_id_next;
    logic [15:0]                 best_rem_reg, best_rem_next;
    logic [31:0]                 tick_reg, tick_next;
    logic                        out_valid_reg, out_valid_next;
    edf_pkg::rsp_word_t          out_word_reg, out_word_next;

    logic [edf_pkg::IDX_W-1:0]   scan_idx;
    logic [7:0]                  cur_id;
    logic [15:0]                 cur_rem;
    logic [15:0]                 cur_dl;
    logic                        better;
    logic                        load_wr;
    logic                        emit;
    logic [edf_pkg::IDX_W-1:0]   load_idx;

    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_word_reg;

    always_comb
    begin
        if (32'(task_count) > 32'(edf_pkg::SLOTS))
        begin
            limit = edf_pkg::CNT_W'(edf_pkg::SLOTS);
        end
        else
        begin
            limit = edf_pkg::CNT_W'(task_count);
        end
    end

    assign scan_idx = idx_reg[edf_pkg::IDX_W-1:0];
    assign cur_id   = ident_reg[scan_idx];
    assign cur_rem  = remain_reg[scan_idx];
    assign cur_dl   = dline_reg[scan_idx];
    assign better   = (cur_rem != '0) &&
                      (!found_reg || (cur_dl < best_dl_reg) ||
                       ((cur_dl == best_dl_reg) && (cur_id < best_id_reg)));
    assign load_idx = edf_pkg::IDX_W'(head.word.slot);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        best_dl_next   = best_dl_reg;
        best_id_next   = best_id_reg;
        best_rem_next  = best_rem_reg;
        tick_next      = tick_reg;
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        pop            = 1'b0;
        load_wr        = 1'b0;
        emit           = 1'b0;
        unique case (state_reg)
            edf_pkg::BK_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    if (head.word.opcode == edf_pkg::OP_LOAD)
                    begin
                        load_wr = (32'(head.word.slot) < 32'(edf_pkg::SLOTS));
                    end
                    else
                    begin
                        idx_next   = '0;
                        found_next = 1'b0;
                        state_next = edf_pkg::BK_SCAN;
                    end
                end
            end
            edf_pkg::BK_SCAN:
            begin
                if (idx_reg == limit)
                begin
                    state_next = edf_pkg::BK_EMIT;
                end
                else
                begin
                    if (better)
                    begin
                        found_next    = 1'b1;
                        best_next     = scan_idx;
                        best_dl_next  = cur_dl;
                        best_id_next  = cur_id;
                        best_rem_next = cur_rem;
                    end
                    idx_next = idx_reg + 1'b1;
                end
            end
            edf_pkg::BK_EMIT:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    emit                   = 1'b1;
                    out_valid_next         = 1'b1;
                    out_word_next.time_now = tick_reg;
                    out_word_next.busy_res = found_reg;
                    out_word_next.run_id   = found_reg ? best_id_reg : 8'd0;
                    out_word_next.finished = found_reg && (best_rem_reg == 16'd1);
                    tick_next              = tick_reg + 32'd1;
                    state_next             = edf_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = edf_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < edf_pkg::SLOTS; i++)
            begin
                ident_reg[i]  <= '0;
                remain_reg[i] <= '0;
                dline_reg[i]  <= '0;
            end
        end
        else if (load_wr)
        begin
            ident_reg[load_idx]  <= head.word.task_id;
            remain_reg[load_idx] <= head.word.exec_time;
            dline_reg[load_idx]  <= head.word.exec_time;
        end
        else if (emit && found_reg)
        begin
            remain_reg[best_reg] <= best_rem_reg - 16'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg     <= best_next;
        best_dl_reg  <= best_dl_next;
        best_id_reg  <= best_id_next;
        best_rem_reg <= best_rem_next;
        out_word_reg <= out_word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= edf_pkg::BK_IDLE;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            found_reg     <= found_next;
            tick_reg      <= tick_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
